// File: hw/rtl/b64w_pkg.sv
`timescale 1ns / 1ps

package b64w_pkg;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic [1:0] count;
    char_t      c0;
    char_t      c1;
  } res_t;

  localparam logic [15:0] MaxLenReset = 16'hffff;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx) inside
      [6'd0:6'd25]:  ch = 8'(idx) + 8'd65;
      [6'd26:6'd51]: ch = 8'(idx) + 8'd71;
      [6'd52:6'd61]: ch = 8'(idx) - 8'd4;
      6'd62:         ch = 8'd95;
      default:       ch = 8'd45;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/b64w_if.sv
`timescale 1ns / 1ps

interface b64w_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64w_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

interface b64w_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_out_len;
  modport source (output valid, output max_out_len, input ready);
  modport sink (input valid, input max_out_len, output ready);
endinterface

// File: hw/rtl/b64w_core.sv
`timescale 1ns / 1ps

module b64w_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i,
  output b64w_pkg::res_t   res_o
);

  logic [15:0]      max_len_q;
  b64w_pkg::phase_e phase_q, phase_d;
  logic [3:0]       carry_q, carry_d;
  logic [3:0]       ftn_q;
  logic             started_q;
  logic [15:0]      sent_q, sent_a, sent_b;
  logic [3:0]       ftn;
  logic [5:0]       idx0, idx1;
  logic             want1, fin1, e0, e1, mark0, mark1;

  always_comb begin
    ftn = started_q ? ftn_q : data_byte_i[7:4];
    case (phase_q)
      b64w_pkg::PH_SECOND: begin
        idx0    = {carry_q[1:0], data_byte_i[7:4]};
        want1   = last_byte_i;
        idx1    = {data_byte_i[3:0], ftn[3:2]};
        fin1    = 1'b1;
        carry_d = data_byte_i[3:0];
        phase_d = b64w_pkg::PH_THIRD;
      end
      b64w_pkg::PH_THIRD: begin
        idx0    = {carry_q, data_byte_i[7:6]};
        want1   = 1'b1;
        idx1    = data_byte_i[5:0];
        fin1    = last_byte_i;
        carry_d = 4'd0;
        phase_d = b64w_pkg::PH_FIRST;
      end
      default: begin
        idx0    = data_byte_i[7:2];
        want1   = last_byte_i;
        idx1    = {data_byte_i[1:0], ftn};
        fin1    = 1'b1;
        carry_d = {2'b00, data_byte_i[1:0]};
        phase_d = b64w_pkg::PH_SECOND;
      end
    endcase
  end

  always_comb begin
    e0     = sent_q < max_len_q;
    sent_a = sent_q + {15'd0, e0};
    mark0  = sent_a == max_len_q;
    e1     = want1 && (sent_a < max_len_q);
    mark1  = fin1 || ((sent_a + 16'd1) == max_len_q);
    sent_b = sent_a + {15'd0, e1};
  end

  assign res_o.count        = {1'b0, e0} + {1'b0, e1};
  assign res_o.c0.out_char  = b64w_pkg::b64_char(idx0);
  assign res_o.c0.last_char = mark0;
  assign res_o.c1.out_char  = b64w_pkg::b64_char(idx1);
  assign res_o.c1.last_char = mark1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= b64w_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= b64w_pkg::PH_FIRST;
      carry_q   <= 4'd0;
      ftn_q     <= 4'd0;
      started_q <= 1'b0;
      sent_q    <= 16'd0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        phase_q   <= b64w_pkg::PH_FIRST;
        carry_q   <= 4'd0;
        ftn_q     <= 4'd0;
        started_q <= 1'b0;
        sent_q    <= 16'd0;
      end else begin
        phase_q   <= phase_d;
        carry_q   <= carry_d;
        ftn_q     <= ftn;
        started_q <= 1'b1;
        sent_q    <= sent_b;
      end
    end
  end

endmodule

// File: hw/rtl/b64w_outbuf.sv
`timescale 1ns / 1ps

module b64w_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  b64w_pkg::res_t    res_i,
  output logic              can_load_o,
  b64w_char_if.source       out_o
);

  b64w_pkg::char_t slot0_q, slot1_q;
  logic [1:0]      cnt_q;
  logic            pop;

  assign pop        = (cnt_q != 2'd0) && out_o.ready;
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  assign out_o.valid     = cnt_q != 2'd0;
  assign out_o.out_char  = slot0_q.out_char;
  assign out_o.last_char = slot0_q.last_char;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // payload: load a fresh pair, or advance the second slot to the head
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot0_q <= res_i.c0;
      slot1_q <= res_i.c1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

endmodule

// File: hw/rtl/base64url_wrap_encoder_top.sv
`timescale 1ns / 1ps

// Unpadded base64-style encoder with length limit; index 62 maps to '_', 63 to '-'.
// in_i   : message bytes (data_byte, last_byte), valid/ready request channel.
// out_o  : characters (out_char, last_char), valid/ready request channel.
// cfg_i  : max_out_len write channel, always ready; write only while idle.
// A byte request is taken in the same cycle its characters (up to two) are
// computed; the first character appears on out_o in the next cycle.
// Throughput: one byte per cycle while out_o is ready and each byte yields at
// most one character; a byte that yields two holds in_i.ready low while the
// one-character-per-cycle output port drains the two-entry result buffer.
// A new byte is taken while the last buffered character is being taken.
// When the receiver stalls, the buffer holds its characters and in_i.ready
// drops until the buffer can take a full pair.
// Reset empties the buffer, clears the message state and sets max_out_len
// to 65535.
module base64url_wrap_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64w_byte_if.sink   in_i,
  b64w_char_if.source out_o,
  b64w_cfg_if.sink    cfg_i
);

  b64w_pkg::res_t res;
  logic           can_load;
  logic           accept;

  assign in_i.ready  = can_load;
  assign accept      = in_i.valid && can_load;
  assign cfg_i.ready = 1'b1;

  b64w_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.max_out_len),
    .res_o       (res)
  );

  b64w_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
